/* rtl/dhpid_pkg.sv */
package dhpid_pkg;

  // accumulator width of the shared multiplier, wide enough for the mixed wheel term
  localparam int AccW = 56;

  // fixed scale factors of the controller
  localparam logic [15:0] TickMs  = 16'd50;
  localparam logic [15:0] AxleLen = 16'd11;
  localparam logic [15:0] VScale  = 16'd25600;
  localparam logic [31:0] DenConst = 32'd76800;
  localparam logic [AccW-1:0] SatLim = 56'd2516582400;
  localparam logic signed [AccW-1:0] WLim = 56'sh4_0000_0000_0000;

  // register indexes
  localparam logic [2:0] RegKpFar     = 3'd0;
  localparam logic [2:0] RegKpNear    = 3'd1;
  localparam logic [2:0] RegKiGain    = 3'd2;
  localparam logic [2:0] RegKdGain    = 3'd3;
  localparam logic [2:0] RegSpeedFar  = 3'd4;
  localparam logic [2:0] RegSpeedNear = 3'd5;
  localparam logic [2:0] RegSlowRad   = 3'd6;
  localparam logic [2:0] RegStopRad   = 3'd7;

  // multiplier command
  typedef struct packed {
    logic start;
    logic clr;
  } mul_cmd_t;

endpackage

/* rtl/diff_drive_heading_pid.sv */
// channel | direction | handshake                 | payload
// input   | in        | in_valid_i / in_stall_o   | pos_x, pos_y, heading, goal_x, goal_y, goal_heading
// output  | out       | out_valid_o / out_stall_i | left_speed, right_speed, stopped
// config  | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// one item at a time; the time from accept to result is set by the bit-serial multiplier
// (8 products, or 2 when stopped), the 13-step square root and, unless stopped, two
// 15-step divisions.
// reset puts registers at their defaults and clears the integral and last error.
// a result waiting on a stalled output does not block the next item from entering.
module diff_drive_heading_pid import dhpid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [11:0] pos_x_i,
  input  logic        [11:0] pos_y_i,
  input  logic        [8:0]  heading_i,
  input  logic        [11:0] goal_x_i,
  input  logic        [11:0] goal_y_i,
  input  logic        [8:0]  goal_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_speed_o,
  output logic signed [15:0] right_speed_o,
  output logic               stopped_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [15:0] cfg_data_i
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StMul    = 4'd1;
  localparam logic [3:0] StMWait  = 4'd2;
  localparam logic [3:0] StSqrt   = 4'd3;
  localparam logic [3:0] StSWait  = 4'd4;
  localparam logic [3:0] StDecide = 4'd5;
  localparam logic [3:0] StDivL   = 4'd6;
  localparam logic [3:0] StDLWait = 4'd7;
  localparam logic [3:0] StDivR   = 4'd8;
  localparam logic [3:0] StDRWait = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;

  localparam logic [2:0] OpDx2  = 3'd0;
  localparam logic [2:0] OpDy2  = 3'd1;
  localparam logic [2:0] OpKpE  = 3'd2;
  localparam logic [2:0] OpKiEs = 3'd3;
  localparam logic [2:0] OpTick = 3'd4;
  localparam logic [2:0] OpKdDe = 3'd5;
  localparam logic [2:0] OpAxle = 3'd6;
  localparam logic [2:0] OpVel  = 3'd7;

  logic [3:0] state_q;
  logic [2:0] op_q;

  logic [15:0] kp_far_q, kp_near_q, ki_q, kd_q;
  logic [9:0]  spd_far_q, spd_near_q;
  logic [12:0] slow_q, stop_q;

  logic [11:0] px_q, py_q, gx_q, gy_q;
  logic [8:0]  hd_q, gh_q;

  logic signed [31:0] es_q;
  logic signed [8:0]  last_q;
  logic signed [8:0]  e_q;
  logic signed [9:0]  de_q;
  logic        [15:0] kp_sel_q;
  logic        [9:0]  v_sel_q;
  logic signed [AccW-1:0] wl_q;

  logic signed [15:0] res_l_q, res_r_q;
  logic               res_stop_q;
  logic               out_valid_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic               out_stop_q;

  mul_cmd_t               mul_cmd;
  logic signed [AccW-1:0] mul_a;
  logic        [15:0]     mul_b;
  logic signed [AccW-1:0] acc;
  logic                   mul_busy;

  logic        [12:0] root;
  logic               sqrt_busy;
  logic signed [AccW-1:0] div_num;
  logic signed [15:0] div_q;
  logic               div_busy;

  logic signed [12:0] dx, dy;
  logic        [11:0] adx, ady;
  logic signed [AccW-1:0] wclamp;

  logic        [10:0] hsum, r1;
  logic        [8:0]  r2;
  logic signed [8:0]  e_w;
  logic signed [14:0] ese, e50;
  logic signed [32:0] es_sum;
  logic signed [31:0] es_new;
  logic signed [9:0]  de_w;
  logic               is_stop, is_near;
  logic               in_acc, out_acc, out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_far_q   <= 16'd205;
      kp_near_q  <= 16'd102;
      ki_q       <= 16'd0;
      kd_q       <= 16'd12800;
      spd_far_q  <= 10'd420;
      spd_near_q <= 10'd230;
      slow_q     <= 13'd100;
      stop_q     <= 13'd15;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKpFar:     kp_far_q   <= cfg_data_i;
        RegKpNear:    kp_near_q  <= cfg_data_i;
        RegKiGain:    ki_q       <= cfg_data_i;
        RegKdGain:    kd_q       <= cfg_data_i;
        RegSpeedFar:  spd_far_q  <= cfg_data_i[9:0];
        RegSpeedNear: spd_near_q <= cfg_data_i[9:0];
        RegSlowRad:   slow_q     <= cfg_data_i[12:0];
        RegStopRad:   stop_q     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // position deltas
  assign dx  = $signed({1'b0, gx_q}) - $signed({1'b0, px_q});
  assign dy  = $signed({1'b0, gy_q}) - $signed({1'b0, py_q});
  assign adx = dx[12] ? 12'(-dx) : dx[11:0];
  assign ady = dy[12] ? 12'(-dy) : dy[11:0];

  // turn rate clamp
  always_comb begin
    if (acc > WLim) begin
      wclamp = WLim;
    end else if (acc < -WLim) begin
      wclamp = -WLim;
    end else begin
      wclamp = acc;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_cmd.start = (state_q == StMul);
    mul_cmd.clr   = 1'b1;
    mul_a         = '0;
    mul_b         = '0;
    unique case (op_q)
      OpDx2: begin
        mul_a = {{(AccW-12){1'b0}}, adx};
        mul_b = {4'b0, adx};
      end
      OpDy2: begin
        mul_a       = {{(AccW-12){1'b0}}, ady};
        mul_b       = {4'b0, ady};
        mul_cmd.clr = 1'b0;
      end
      OpKpE: begin
        mul_a = {{(AccW-9){e_q[8]}}, e_q};
        mul_b = kp_sel_q;
      end
      OpKiEs: begin
        mul_a       = {{(AccW-32){es_q[31]}}, es_q};
        mul_b       = ki_q;
        mul_cmd.clr = 1'b0;
      end
      OpTick: begin
        mul_a = acc;
        mul_b = TickMs;
      end
      OpKdDe: begin
        mul_a       = {{(AccW-10){de_q[9]}}, de_q};
        mul_b       = kd_q;
        mul_cmd.clr = 1'b0;
      end
      OpAxle: begin
        mul_a = wclamp;
        mul_b = AxleLen;
      end
      OpVel: begin
        mul_a = {{(AccW-10){1'b0}}, v_sel_q};
        mul_b = VScale;
      end
      default: ;
    endcase
  end

  dhpid_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .acc_o  (acc),
    .busy_o (mul_busy)
  );

  dhpid_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == StSqrt),
    .val_i   (acc[24:0]),
    .root_o  (root),
    .busy_o  (sqrt_busy)
  );

  assign div_num = (state_q == StDivL) ? acc + wl_q : acc - wl_q;

  dhpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == StDivL) || (state_q == StDivR)),
    .num_i   (div_num),
    .q_o     (div_q),
    .busy_o  (div_busy)
  );

  // heading error wrap, integral and error-delta update, and distance compares
  always_comb begin
    hsum = 11'({2'b0, hd_q}) + 11'd720 - 11'({2'b0, gh_q});
    r1   = (hsum >= 11'd720) ? hsum - 11'd720 : hsum;
    r2   = (r1 >= 11'd360) ? 9'(r1 - 11'd360) : r1[8:0];
    e_w  = (r2 > 9'd180) ? $signed(r2 - 9'd360) : $signed(r2);
    ese  = {{6{e_w[8]}}, e_w};
    e50  = (ese <<< 5) + (ese <<< 4) + (ese <<< 1);
    es_sum = {es_q[31], es_q} + {{18{e50[14]}}, e50};
    if (es_sum[32] != es_sum[31]) begin
      es_new = es_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      es_new = es_sum[31:0];
    end
    de_w    = {e_w[8], e_w} - {last_q[8], last_q};
    is_stop = (root <= stop_q);
    is_near = (root < slow_q);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpDx2;
      es_q        <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_acc && !((state_q == StOut) && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            op_q    <= OpDx2;
            state_q <= StMul;
          end
        end
        StMul: state_q <= StMWait;
        StMWait: begin
          if (!mul_busy) begin
            op_q <= op_q + 3'd1;
            if (op_q == OpDy2) begin
              state_q <= StSqrt;
            end else if (op_q == OpVel) begin
              state_q <= StDivL;
            end else begin
              state_q <= StMul;
            end
          end
        end
        StSqrt: state_q <= StSWait;
        StSWait: begin
          if (!sqrt_busy) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (is_stop) begin
            state_q <= StOut;
          end else begin
            es_q    <= es_new;
            last_q  <= e_w;
            state_q <= StMul;
          end
        end
        StDivL: state_q <= StDLWait;
        StDLWait: begin
          if (!div_busy) begin
            state_q <= StDivR;
          end
        end
        StDivR: state_q <= StDRWait;
        StDRWait: begin
          if (!div_busy) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      hd_q <= heading_i;
      gx_q <= goal_x_i;
      gy_q <= goal_y_i;
      gh_q <= goal_heading_i;
    end
    if (state_q == StDecide) begin
      e_q        <= e_w;
      de_q       <= de_w;
      kp_sel_q   <= is_near ? kp_near_q : kp_far_q;
      v_sel_q    <= is_near ? spd_near_q : spd_far_q;
      res_stop_q <= is_stop;
      res_l_q    <= '0;
      res_r_q    <= '0;
    end
    if ((state_q == StMul) && (op_q == OpVel)) begin
      wl_q <= acc;
    end
    if ((state_q == StDLWait) && !div_busy) begin
      res_l_q <= div_q;
    end
    if ((state_q == StDRWait) && !div_busy) begin
      res_r_q <= div_q;
    end
    if ((state_q == StOut) && out_free) begin
      out_l_q    <= res_l_q;
      out_r_q    <= res_r_q;
      out_stop_q <= res_stop_q;
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = out_l_q;
  assign right_speed_o = out_r_q;
  assign stopped_o     = out_stop_q;

`ifndef ASSERT_OFF
  // a stopped result carries zero speeds
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_o |-> (left_speed_o == 16'sd0) && (right_speed_o == 16'sd0))
    else $error("stopped result with nonzero speed");

  // an accepted item holds off the next one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // no arithmetic unit runs while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !mul_busy && !sqrt_busy && !div_busy)
    else $error("unit busy in idle");
`endif

endmodule

/* rtl/dhpid_mul.sv */
module dhpid_mul import dhpid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mul_cmd_t               cmd_i,
  input  logic signed [AccW-1:0] a_i,
  input  logic        [15:0]     b_i,
  output logic signed [AccW-1:0] acc_o,
  output logic                   busy_o
);

  logic        [15:0]     b_q;
  logic signed [AccW-1:0] a_q;
  logic signed [AccW-1:0] acc_q;

  // multiplier bits, one retired per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (cmd_i.start) begin
      b_q <= b_i;
    end else begin
      b_q <= b_q >> 1;
    end
  end

  // shifted multiplicand and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= a_i;
      if (cmd_i.clr) begin
        acc_q <= '0;
      end
    end else if (b_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q <<< 1;
    end
  end

  assign busy_o = (b_q != '0);
  assign acc_o  = acc_q;

endmodule

/* rtl/dhpid_sqrt.sv */
module dhpid_sqrt import dhpid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [24:0] val_i,
  output logic [12:0] root_o,
  output logic        busy_o
);

  logic [24:0] bit_q;
  logic [24:0] v_q;
  logic [24:0] res_q;
  logic [25:0] sum;
  logic        ge;

  // trial value for the current root bit
  assign sum = {1'b0, res_q} + {1'b0, bit_q};
  assign ge  = ({1'b0, v_q} >= sum);

  // one-hot bit pair pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= 25'h100_0000;
    end else begin
      bit_q <= bit_q >> 2;
    end
  end

  // remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (ge) begin
        v_q   <= v_q - sum[24:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign root_o = res_q[12:0];
  assign busy_o = (bit_q != '0);

endmodule

/* rtl/dhpid_div.sv */
module dhpid_div import dhpid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AccW-1:0] num_i,
  output logic signed [15:0]     q_o,
  output logic                   busy_o
);

  logic [14:0]     qb_q;
  logic [14:0]     q_q;
  logic [31:0]     rem_q;
  logic [31:0]     dsh_q;
  logic            neg_q;
  logic            sat_q;
  logic [AccW-1:0] mag;
  logic            ge;

  // magnitude of the numerator
  assign mag = num_i[AccW-1] ? AccW'(-num_i) : AccW'(num_i);
  assign ge  = (rem_q >= dsh_q);

  // one-hot quotient bit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qb_q <= '0;
    end else if (start_i) begin
      qb_q <= (mag >= SatLim) ? 15'd0 : 15'h4000;
    end else begin
      qb_q <= qb_q >> 1;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[AccW-1];
      sat_q <= (mag >= SatLim);
      rem_q <= mag[31:0];
      dsh_q <= DenConst << 14;
      q_q   <= '0;
    end else if (qb_q != '0) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
        q_q   <= q_q | qb_q;
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // sign and saturation
  always_comb begin
    if (sat_q) begin
      q_o = neg_q ? 16'sh8000 : 16'sh7fff;
    end else if (neg_q) begin
      q_o = -$signed({1'b0, q_q});
    end else begin
      q_o = $signed({1'b0, q_q});
    end
  end

  assign busy_o = (qb_q != '0);

endmodule
